// ===== hdl/efd_pkg.sv =====
// Shared constants and types for the escaped frame deframer.
`timescale 1ns / 1ps

package efd_pkg;

	localparam logic [7:0] HDR_BYTE     = 8'h5A;
	localparam logic [7:0] ESC_BYTE     = 8'h5B;
	localparam logic [7:0] ESC_HDR_CODE = 8'h3A;
	localparam logic [7:0] ESC_ESC_CODE = 8'h3B;

	localparam int POS_W = 17;
	localparam logic [POS_W-1:0] PAYLOAD_START = POS_W'(8);

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_CSUM    = 2'd1;
	localparam logic [1:0] STATUS_BAD_ESC = 2'd2;

	typedef struct packed {
		logic        frame_end;
		logic [15:0] dest_address;
		logic [15:0] source_address;
		logic [7:0]  command_code;
		logic [15:0] payload_length;
		logic [15:0] byte_index;
		logic [7:0]  data_byte;
		logic [1:0]  frame_status;
	} result_t;

endpackage

// ===== hdl/efd_if.sv =====
// Stream interfaces for received bytes and deframed results.
`timescale 1ns / 1ps

interface efd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface efd_result_if;
	logic        valid;
	logic        ready;
	logic        frame_end;
	logic [15:0] dest_address;
	logic [15:0] source_address;
	logic [7:0]  command_code;
	logic [15:0] payload_length;
	logic [15:0] byte_index;
	logic [7:0]  data_byte;
	logic [1:0]  frame_status;

	modport source (
		output valid, output frame_end, output dest_address, output source_address,
		output command_code, output payload_length, output byte_index,
		output data_byte, output frame_status, input ready
	);
	modport sink (
		input valid, input frame_end, input dest_address, input source_address,
		input command_code, input payload_length, input byte_index,
		input data_byte, input frame_status, output ready
	);
endinterface

// ===== hdl/efd_core.sv =====
// Frame state, escape decoding, header capture and checksum for one byte per cycle while take is high.
`timescale 1ns / 1ps

module efd_core
	import efd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] rx_byte,
	output logic       res_valid,
	output result_t    res
);

	logic             in_frame_q, esc_q;
	logic [POS_W-1:0] pos_q;
	logic [15:0]      dest_q, src_q, len_q;
	logic [7:0]       cmd_q, csum_q;

	logic             in_frame_d, esc_d;
	logic [POS_W-1:0] pos_d;
	logic [15:0]      dest_d, src_d, len_d;
	logic [7:0]       cmd_d, csum_d;

	logic             have_byte;
	logic [7:0]       b;
	logic [POS_W-1:0] idx;

	always_comb begin
		in_frame_d = in_frame_q;
		esc_d      = esc_q;
		pos_d      = pos_q;
		dest_d     = dest_q;
		src_d      = src_q;
		len_d      = len_q;
		cmd_d      = cmd_q;
		csum_d     = csum_q;
		have_byte  = 1'b0;
		b          = rx_byte;
		idx        = pos_q - PAYLOAD_START;
		res_valid  = 1'b0;
		res.frame_end      = 1'b0;
		res.dest_address   = dest_q;
		res.source_address = src_q;
		res.command_code   = cmd_q;
		res.payload_length = len_q;
		res.byte_index     = idx[15:0];
		res.data_byte      = rx_byte;
		res.frame_status   = STATUS_OK;

		if (!in_frame_q) begin
			if (rx_byte == HDR_BYTE) begin
				in_frame_d = 1'b1;
				pos_d      = POS_W'(1);
				dest_d = '0; src_d = '0; len_d = '0; cmd_d = '0; csum_d = '0;
			end
		end else if (esc_q) begin
			esc_d = 1'b0;
			if (rx_byte == ESC_HDR_CODE) begin
				have_byte = 1'b1;
				b         = HDR_BYTE;
			end else if (rx_byte == ESC_ESC_CODE) begin
				have_byte = 1'b1;
				b         = ESC_BYTE;
			end else begin
				res_valid          = 1'b1;
				res.frame_end      = 1'b1;
				res.byte_index     = '0;
				res.data_byte      = '0;
				res.frame_status   = STATUS_BAD_ESC;
				in_frame_d         = 1'b0;
				pos_d              = '0;
				// a raw header as the bad code opens the next frame at once
				if (rx_byte == HDR_BYTE) begin
					in_frame_d = 1'b1;
					pos_d      = POS_W'(1);
					dest_d = '0; src_d = '0; len_d = '0; cmd_d = '0; csum_d = '0;
				end
			end
		end else if (rx_byte == HDR_BYTE) begin
			pos_d  = POS_W'(1);
			dest_d = '0; src_d = '0; len_d = '0; cmd_d = '0; csum_d = '0;
		end else if (rx_byte == ESC_BYTE) begin
			esc_d = 1'b1;
		end else begin
			have_byte = 1'b1;
		end

		if (have_byte) begin
			res.data_byte = b;
			pos_d = pos_q + POS_W'(1);
			unique case (pos_q)
				POS_W'(1): dest_d = {b, 8'h00};
				POS_W'(2): dest_d = {dest_q[15:8], b};
				POS_W'(3): src_d  = {b, 8'h00};
				POS_W'(4): src_d  = {src_q[15:8], b};
				POS_W'(5): begin
					cmd_d  = b;
					csum_d = csum_q ^ b;
				end
				POS_W'(6): begin
					len_d  = {b, 8'h00};
					csum_d = csum_q ^ b;
				end
				POS_W'(7): begin
					len_d  = {len_q[15:8], b};
					csum_d = csum_q ^ b;
				end
				default: begin
					res_valid = 1'b1;
					if (idx < {1'b0, len_q}) begin
						csum_d = csum_q ^ b;
					end else begin
						// closing checksum byte
						res.frame_end    = 1'b1;
						res.byte_index   = '0;
						res.data_byte    = '0;
						res.frame_status = (csum_q == b) ? STATUS_OK : STATUS_CSUM;
						in_frame_d       = 1'b0;
						esc_d            = 1'b0;
						pos_d            = '0;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			esc_q      <= 1'b0;
			pos_q      <= '0;
		end else if (take) begin
			in_frame_q <= in_frame_d;
			esc_q      <= esc_d;
			pos_q      <= pos_d;
		end
	end

	// header fields are cleared at every frame start
	always_ff @(posedge clk) begin
		if (take) begin
			dest_q <= dest_d;
			src_q  <= src_d;
			len_q  <= len_d;
			cmd_q  <= cmd_d;
			csum_q <= csum_d;
		end
	end

endmodule

// ===== hdl/efd_skid.sv =====
// Two-entry result buffer; the input side sees a registered ready.
`timescale 1ns / 1ps

module efd_skid
	import efd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    can_push,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	result_t     ent0_q, ent1_q;
	logic [1:0]  cnt_q;
	logic        pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = (cnt_q != 2'd0);
	assign can_push  = (cnt_q != 2'd2);
	assign out_data  = ent0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case ({push, pop})
			2'b10: begin
				if (cnt_q == 2'd0) ent0_q <= push_data;
				else ent1_q <= push_data;
			end
			2'b01: ent0_q <= ent1_q;
			2'b11: begin
				if (cnt_q == 2'd1) begin
					ent0_q <= push_data;
				end else begin
					ent0_q <= ent1_q;
					ent1_q <= push_data;
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== hdl/escaped_frame_deframer_xor.sv =====
// Top level of the escaped frame deframer with XOR checksum.
//
//  channel | dir | payload                                   | handshake
//  rx      | in  | rx_byte                                   | valid/ready
//  res     | out | frame_end, addresses, command, length,    | valid/ready
//          |     | byte_index, data_byte, frame_status       |
//
// One byte is taken per cycle while rx.ready is high; at most one result per byte, decoded
// combinationally from the frame state and registered into the result buffer.
// Reset clears the frame state (hunting for a header) and empties the result buffer.
// A two-entry buffer holds results, so input keeps flowing while one result waits;
// rx.ready drops only when both entries are full.
`timescale 1ns / 1ps

module escaped_frame_deframer_xor
	import efd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	efd_byte_if.sink     rx,
	efd_result_if.source res
);

	logic    take, core_valid, can_push;
	result_t core_res, out_data;

	assign rx.ready = can_push;
	assign take     = rx.valid && can_push;

	efd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.rx_byte   (rx.rx_byte),
		.res_valid (core_valid),
		.res       (core_res)
	);

	efd_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take && core_valid),
		.push_data (core_res),
		.can_push  (can_push),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.out_data  (out_data)
	);

	assign res.frame_end      = out_data.frame_end;
	assign res.dest_address   = out_data.dest_address;
	assign res.source_address = out_data.source_address;
	assign res.command_code   = out_data.command_code;
	assign res.payload_length = out_data.payload_length;
	assign res.byte_index     = out_data.byte_index;
	assign res.data_byte      = out_data.data_byte;
	assign res.frame_status   = out_data.frame_status;

endmodule
